>>> src/cmnm_pkg.sv
// Shared types and constants of the cone map nearest-match block.
// No dependencies; every other file of the block imports this package.
package cmnm_pkg;

    localparam int MAP_DEPTH = 64;
    localparam int IDX_W     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int CNT_W     = $clog2(MAP_DEPTH + 1);

    localparam int POS_W     = 16;
    localparam int COLOR_W   = 4;
    localparam int CFG_W     = 15;
    localparam int DIFF_W    = POS_W + 1;
    localparam int SQ_W      = 2 * POS_W;
    localparam int ACC_W     = SQ_W + 1;
    localparam int SLOT_W    = 6;
    localparam int ACTION_W  = 3;
    localparam int COUNT_W   = 7;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CFG_W-1:0]   MATCH_DIST_RST  = 15'd384;
    localparam logic [CFG_W-1:0]   RANGE_LIMIT_RST = 15'd3840;
    localparam logic [COLOR_W-1:0] COLOR_UNKNOWN   = 4'd4;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic {
        OP_DETECT = 1'b0,
        OP_DUMP   = 1'b1
    } t_op;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_ENTRY  = 1'b1
    } t_kind;

    typedef enum logic [ACTION_W-1:0] {
        ACT_OUT_OF_RANGE = 3'd0,
        ACT_IGNORED      = 3'd1,
        ACT_REPLACED     = 3'd2,
        ACT_ADDED        = 3'd3,
        ACT_MAP_FULL     = 3'd4
    } t_action;

    // register index = paddr[2]
    typedef enum logic {
        REG_MATCH_DIST  = 1'b0,
        REG_RANGE_LIMIT = 1'b1
    } t_reg;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [COLOR_W-1:0]      color;
    } t_entry;

    // one operand into the squaring unit
    typedef struct packed {
        logic                     en;
        logic                     first;   // start a new sum
        logic signed [DIFF_W-1:0] a;
    } t_feed;

    typedef struct packed {
        t_kind                   kind;
        t_action                 action;
        logic [SLOT_W-1:0]       slot;
        logic signed [POS_W-1:0] entry_x;
        logic signed [POS_W-1:0] entry_y;
        logic [COLOR_W-1:0]      entry_color;
        logic                    entry_valid;
        logic [COUNT_W-1:0]      map_count;
        logic                    last;
    } t_result;

endpackage

>>> src/cmnm_sq_unit.sv
// Shared squaring accumulator: registered 17x17 square, then a running sum.
// Depends on cmnm_pkg. Each square is registered, then added into the registered sum.
module cmnm_sq_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cmnm_pkg::t_feed          i_feed,
    output logic [cmnm_pkg::ACC_W-1:0] o_acc
);
    import cmnm_pkg::*;

    logic signed [2*DIFF_W-1:0] w_prod;
    logic [SQ_W-1:0]            r_sq;
    logic                       r_en1;
    logic                       r_first1;
    logic [ACC_W-1:0]           r_acc;

    // |a| <= 65535, so the square fits SQ_W bits
    assign w_prod = i_feed.a * i_feed.a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en1 <= 1'b0;
        end else begin
            r_en1 <= i_feed.en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq     <= w_prod[SQ_W-1:0];
        r_first1 <= i_feed.first;
        if (r_en1) begin
            r_acc <= (r_first1 ? '0 : r_acc) + ACC_W'(r_sq);
        end
    end

    assign o_acc = r_acc;

endmodule

>>> src/cmnm_cfg_regs.sv
// APB register file: match distance and range limit.
// Depends on cmnm_pkg.
module cmnm_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cmnm_pkg::PADDR_W-1:0]  paddr,
    input  logic [cmnm_pkg::PDATA_W-1:0]  pwdata,
    output logic [cmnm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [cmnm_pkg::CFG_W-1:0]    o_match_distance,
    output logic [cmnm_pkg::CFG_W-1:0]    o_range_limit
);
    import cmnm_pkg::*;

    logic [CFG_W-1:0] r_match_distance;
    logic [CFG_W-1:0] r_range_limit;
    logic             w_wr;
    t_reg             w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_distance <= MATCH_DIST_RST;
            r_range_limit    <= RANGE_LIMIT_RST;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_MATCH_DIST:  r_match_distance <= pwdata[CFG_W-1:0];
                REG_RANGE_LIMIT: r_range_limit    <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_MATCH_DIST:  prdata = PDATA_W'(r_match_distance);
            REG_RANGE_LIMIT: prdata = PDATA_W'(r_range_limit);
        endcase
    end

    assign o_match_distance = r_match_distance;
    assign o_range_limit    = r_range_limit;

endmodule

>>> src/cone_map_nearest_match_unit.sv
// Top level: landmark map, sequencer and result register of the cone map matcher.
// Depends on cmnm_pkg, cmnm_sq_unit and cmnm_cfg_regs.
//
// A request is taken when start is high and busy is low; busy stays high until the
// request is done. A detection is first checked against the range limit and ends there
// when it is out of range; in the first frame, or on an empty map in a later frame, it
// is appended at once, and otherwise every map entry is searched for the nearest one
// before it is ignored or appended, with each entry behind a conflicting match moved
// down one slot first. The per-entry search steps come from the single squaring unit
// (dx^2 then dy^2, two stages) and the map's one read port. An end-of-frame request
// keeps busy high while the map streams out of the registered read port at one entry per cycle; an empty
// map gives its single result the next cycle without raising busy. Every result is
// shown for exactly one cycle with o_result_valid; the receiver cannot stall, so
// results must be taken as they come. The last result of a request carries o_last,
// and busy is low in that same cycle.
module cone_map_nearest_match_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_op,
    input  logic signed [cmnm_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [cmnm_pkg::POS_W-1:0] i_pos_y,
    input  logic [cmnm_pkg::COLOR_W-1:0]      i_cone_color,
    output logic                              o_result_valid,
    output logic                              o_kind,
    output logic [cmnm_pkg::ACTION_W-1:0]     o_action,
    output logic [cmnm_pkg::SLOT_W-1:0]       o_slot,
    output logic signed [cmnm_pkg::POS_W-1:0] o_entry_x,
    output logic signed [cmnm_pkg::POS_W-1:0] o_entry_y,
    output logic [cmnm_pkg::COLOR_W-1:0]      o_entry_color,
    output logic                              o_entry_valid,
    output logic [cmnm_pkg::COUNT_W-1:0]      o_map_count,
    output logic                              o_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cmnm_pkg::PADDR_W-1:0]      paddr,
    input  logic [cmnm_pkg::PDATA_W-1:0]      pwdata,
    output logic [cmnm_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import cmnm_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_RNG    = 16'h0002,
        S_PX     = 16'h0004,
        S_PY     = 16'h0008,
        S_MD     = 16'h0010,
        S_RCHK   = 16'h0020,
        S_MLIM   = 16'h0040,
        S_SX     = 16'h0080,
        S_SY     = 16'h0100,
        S_SW     = 16'h0200,
        S_SC     = 16'h0400,
        S_DECIDE = 16'h0800,
        S_SHIFT  = 16'h1000,
        S_APPEND = 16'h2000,
        S_DUMP   = 16'h4000,
        S_SPARE  = 16'h8000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0] w_match_distance;
    logic [CFG_W-1:0] w_range_limit;
    t_feed            w_feed;
    logic [ACC_W-1:0] w_acc;

    logic signed [POS_W-1:0] r_x, n_x;
    logic signed [POS_W-1:0] r_y, n_y;
    logic [COLOR_W-1:0]      r_c, n_c;
    t_cnt                    r_count, n_count;
    logic                    r_first_frame, n_first_frame;
    t_idx                    r_idx, n_idx;
    t_idx                    r_best_idx, n_best_idx;
    logic [ACC_W-1:0]        r_best, n_best;
    logic [ACC_W-1:0]        r_lim, n_lim;
    logic [ACC_W-1:0]        r_mlim, n_mlim;
    logic                    r_repl, n_repl;
    t_result                 r_res, n_res;
    logic                    r_res_vld, n_res_vld;

    t_entry r_mem [MAP_DEPTH];
    t_entry r_rd;
    logic   w_we;
    t_idx   w_waddr;
    t_entry w_wdata;
    t_idx   w_raddr;

    t_idx   w_idx_next;
    logic   w_more;

    cmnm_cfg_regs u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_match_distance (w_match_distance),
        .o_range_limit    (w_range_limit)
    );

    cmnm_sq_unit u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_feed  (w_feed),
        .o_acc   (w_acc)
    );

    function automatic t_result status_res(t_action act, t_idx slot, t_cnt cnt);
        t_result res;
        res           = '0;
        res.kind      = KIND_STATUS;
        res.action    = act;
        res.slot      = SLOT_W'(slot);
        res.map_count = COUNT_W'(cnt);
        res.last      = 1'b1;
        return res;
    endfunction

    assign w_idx_next = r_idx + 1'b1;
    assign w_more     = (CNT_W'(r_idx) + CNT_W'(1)) < r_count;

    always_comb begin
        n_state       = r_state;
        n_x           = r_x;
        n_y           = r_y;
        n_c           = r_c;
        n_count       = r_count;
        n_first_frame = r_first_frame;
        n_idx         = r_idx;
        n_best_idx    = r_best_idx;
        n_best        = r_best;
        n_lim         = r_lim;
        n_mlim        = r_mlim;
        n_repl        = r_repl;
        n_res         = r_res;
        n_res_vld     = 1'b0;
        w_feed        = '0;
        w_we          = 1'b0;
        w_waddr       = r_idx;
        w_wdata       = r_rd;
        w_raddr       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_x    = i_pos_x;
                    n_y    = i_pos_y;
                    n_c    = i_cone_color;
                    n_repl = 1'b0;
                    if (t_op'(i_op) == OP_DUMP) begin
                        n_first_frame = 1'b0;
                        n_idx         = '0;
                        if (r_count == '0) begin
                            n_res             = '0;
                            n_res.kind        = KIND_ENTRY;
                            n_res.last        = 1'b1;
                            n_res_vld         = 1'b1;
                        end else begin
                            n_state = S_DUMP;
                        end
                    end else begin
                        n_state = S_RNG;
                    end
                end
            end
            S_RNG: begin
                w_feed  = '{en: 1'b1, first: 1'b1, a: DIFF_W'(w_range_limit)};
                n_state = S_PX;
            end
            S_PX: begin
                w_feed  = '{en: 1'b1, first: 1'b1, a: DIFF_W'(r_x)};
                n_state = S_PY;
            end
            S_PY: begin
                w_feed  = '{en: 1'b1, first: 1'b0, a: DIFF_W'(r_y)};
                n_lim   = w_acc;
                n_state = S_MD;
            end
            S_MD: begin
                w_feed  = '{en: 1'b1, first: 1'b1, a: DIFF_W'(w_match_distance)};
                n_state = S_RCHK;
            end
            S_RCHK: begin
                if (w_acc > r_lim) begin
                    n_res     = status_res(ACT_OUT_OF_RANGE, '0, r_count);
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_first_frame) begin
                    n_state = S_APPEND;
                end else begin
                    n_state = S_MLIM;
                end
            end
            S_MLIM: begin
                n_mlim  = w_acc;
                n_idx   = '0;
                n_state = (r_count == '0) ? S_APPEND : S_SX;
            end
            S_SX: begin
                w_feed  = '{en: 1'b1, first: 1'b1,
                            a: DIFF_W'(r_x) - DIFF_W'(r_rd.x)};
                // hold the entry on the read port for the y term
                w_raddr = r_idx;
                n_state = S_SY;
            end
            S_SY: begin
                w_feed  = '{en: 1'b1, first: 1'b0,
                            a: DIFF_W'(r_y) - DIFF_W'(r_rd.y)};
                n_state = S_SW;
            end
            S_SW: begin
                n_state = S_SC;
            end
            S_SC: begin
                // strict less-than keeps the first entry on ties
                if ((r_idx == '0) || (w_acc < r_best)) begin
                    n_best     = w_acc;
                    n_best_idx = r_idx;
                end
                if (w_more) begin
                    n_idx   = w_idx_next;
                    w_raddr = w_idx_next;
                    n_state = S_SX;
                end else begin
                    w_raddr = n_best_idx;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_APPEND;
                if (r_best <= r_mlim) begin
                    if ((r_rd.color == r_c) || (r_c == COLOR_UNKNOWN)) begin
                        n_res     = status_res(ACT_IGNORED, r_best_idx, r_count);
                        n_res_vld = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        // conflicting match: close the gap, then append
                        n_repl = 1'b1;
                        n_idx  = r_best_idx;
                        if ((CNT_W'(r_best_idx) + CNT_W'(1)) < r_count) begin
                            w_raddr = r_best_idx + 1'b1;
                            n_state = S_SHIFT;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
            end
            S_SHIFT: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = r_rd;
                if ((CNT_W'(r_idx) + CNT_W'(2)) < r_count) begin
                    n_idx   = w_idx_next;
                    w_raddr = r_idx + IDX_W'(2);
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                n_state = S_IDLE;
                n_res_vld = 1'b1;
                if (r_count >= CNT_W'(MAP_DEPTH)) begin
                    n_res = status_res(ACT_MAP_FULL, '0, r_count);
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_count[IDX_W-1:0];
                    w_wdata = '{x: r_x, y: r_y, color: r_c};
                    n_count = r_count + 1'b1;
                    n_res   = status_res(r_repl ? ACT_REPLACED : ACT_ADDED,
                                         r_count[IDX_W-1:0], n_count);
                end
            end
            S_DUMP: begin
                n_res             = '0;
                n_res.kind        = KIND_ENTRY;
                n_res.slot        = SLOT_W'(r_idx);
                n_res.entry_x     = r_rd.x;
                n_res.entry_y     = r_rd.y;
                n_res.entry_color = r_rd.color;
                n_res.entry_valid = 1'b1;
                n_res.map_count   = COUNT_W'(r_count);
                n_res.last        = !w_more;
                n_res_vld         = 1'b1;
                if (w_more) begin
                    n_idx   = w_idx_next;
                    w_raddr = w_idx_next;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_first_frame <= 1'b1;
            r_res_vld     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_first_frame <= n_first_frame;
            r_res_vld     <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_c        <= n_c;
        r_idx      <= n_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_lim      <= n_lim;
        r_mlim     <= n_mlim;
        r_repl     <= n_repl;
        r_res      <= n_res;
    end

    // map store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_vld;
    assign o_kind         = r_res.kind;
    assign o_action       = r_res.action;
    assign o_slot         = r_res.slot;
    assign o_entry_x      = r_res.entry_x;
    assign o_entry_y      = r_res.entry_y;
    assign o_entry_color  = r_res.entry_color;
    assign o_entry_valid  = r_res.entry_valid;
    assign o_map_count    = r_res.map_count;
    assign o_last         = r_res.last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAP_DEPTH))
        else $error("map count beyond depth");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_kind == KIND_STATUS)) |-> o_last)
        else $error("detection status without last");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last) |-> !busy)
        else $error("busy after final result");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> (r_count == $past(r_count)))
        else $error("map count changed while idle");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for cone_map_nearest_match_unit: directed table, then randomized
// detections and dumps over several register settings. Depends on cmnm_pkg and the block.
module testbench;
    import cmnm_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 40;
    localparam int N_PHASES     = 6;
    localparam int N_DIRECTED   = 17;
    localparam int MAX_REPORTED = 10;

    localparam logic [COLOR_W-1:0] COLOR_BLUE   = 4'd0;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW = 4'd1;

    // match distance / range limit per random phase, extremes included
    localparam logic [CFG_W-1:0] PHASE_MATCH [N_PHASES] = '{
        15'd0, 15'd384, 15'd32767, 15'd1500, 15'd700, 15'd200};
    localparam logic [CFG_W-1:0] PHASE_RANGE [N_PHASES] = '{
        15'd32767, 15'd3840, 15'd32767, 15'd0, 15'd5000, 15'd20000};

    typedef struct packed {
        t_op                     op;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [COLOR_W-1:0]      color;
        logic                    typed;     // status written out in the row
        t_action                 action;
        logic [SLOT_W-1:0]       slot;
        logic [COUNT_W-1:0]      count;
    } t_stim_row;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start   = 1'b0;
    logic                      busy;
    logic                      i_op    = 1'b0;
    logic signed [POS_W-1:0]   i_pos_x = '0;
    logic signed [POS_W-1:0]   i_pos_y = '0;
    logic [COLOR_W-1:0]        i_cone_color = '0;
    logic                      o_result_valid;
    logic                      o_kind;
    logic [ACTION_W-1:0]       o_action;
    logic [SLOT_W-1:0]         o_slot;
    logic signed [POS_W-1:0]   o_entry_x;
    logic signed [POS_W-1:0]   o_entry_y;
    logic [COLOR_W-1:0]        o_entry_color;
    logic                      o_entry_valid;
    logic [COUNT_W-1:0]        o_map_count;
    logic                      o_last;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [PADDR_W-1:0]        paddr   = '0;
    logic [PDATA_W-1:0]        pwdata  = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    // predicted landmark map and registers
    t_entry           landmarks [MAP_DEPTH];
    int               landmark_cnt     = 0;
    bit               first_frame_open = 1'b1;
    logic [CFG_W-1:0] match_dist       = MATCH_DIST_RST;
    logic [CFG_W-1:0] range_lim        = RANGE_LIMIT_RST;
    t_result          predicted_reports [$];

    int mismatches   = 0;
    int stall_cycles = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        // first frame: everything in range is appended
        '{OP_DETECT, 16'sd0,     16'sd0,     COLOR_BLUE,    1'b1, ACT_ADDED,        6'd0, 7'd1},
        '{OP_DETECT, 16'sd3840,  16'sd0,     COLOR_YELLOW,  1'b1, ACT_ADDED,        6'd1, 7'd2},
        '{OP_DETECT, 16'sd3841,  16'sd0,     COLOR_YELLOW,  1'b1, ACT_OUT_OF_RANGE, 6'd0, 7'd2},
        '{OP_DETECT, 16'sh8000,  16'sh8000,  4'd15,         1'b1, ACT_OUT_OF_RANGE, 6'd0, 7'd2},
        '{OP_DETECT, 16'sh7FFF,  16'sh7FFF,  4'd15,         1'b1, ACT_OUT_OF_RANGE, 6'd0, 7'd2},
        '{OP_DETECT, 16'sd0,     -16'sd3840, 4'd14,         1'b1, ACT_ADDED,        6'd2, 7'd3},
        '{OP_DETECT, 16'sd5,     16'sd5,     COLOR_BLUE,    1'b1, ACT_ADDED,        6'd3, 7'd4},
        '{OP_DUMP,   16'sd0,     16'sd0,     4'd0,          1'b0, ACT_OUT_OF_RANGE, 6'd0, 7'd0},
        // later frames: nearest search
        '{OP_DETECT, 16'sd0,     16'sd0,     COLOR_UNKNOWN, 1'b1, ACT_IGNORED,      6'd0, 7'd4},
        '{OP_DETECT, 16'sd2,     16'sd3,     COLOR_BLUE,    1'b0, ACT_OUT_OF_RANGE, 6'd0, 7'd0},
        '{OP_DETECT, 16'sd3840,  16'sd384,   COLOR_YELLOW,  1'b0, ACT_OUT_OF_RANGE, 6'd0, 7'd0},
        '{OP_DETECT, 16'sd3840,  16'sd385,   COLOR_YELLOW,  1'b0, ACT_OUT_OF_RANGE, 6'd0, 7'd0},
        '{OP_DETECT, 16'sd0,     -16'sd3800, COLOR_BLUE,    1'b0, ACT_OUT_OF_RANGE, 6'd0, 7'd0},
        '{OP_DETECT, -16'sd2000, 16'sd1000,  4'd9,          1'b0, ACT_OUT_OF_RANGE, 6'd0, 7'd0},
        '{OP_DETECT, -16'sd3840, 16'sd0,     4'd15,         1'b0, ACT_OUT_OF_RANGE, 6'd0, 7'd0},
        '{OP_DETECT, 16'sd0,     -16'sd3840, COLOR_UNKNOWN, 1'b0, ACT_OUT_OF_RANGE, 6'd0, 7'd0},
        '{OP_DUMP,   16'sh7FFF,  16'sh8000,  4'd15,         1'b0, ACT_OUT_OF_RANGE, 6'd0, 7'd0}
    };

    cone_map_nearest_match_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_cone_color   (i_cone_color),
        .o_result_valid (o_result_valid),
        .o_kind         (o_kind),
        .o_action       (o_action),
        .o_slot         (o_slot),
        .o_entry_x      (o_entry_x),
        .o_entry_y      (o_entry_y),
        .o_entry_color  (o_entry_color),
        .o_entry_valid  (o_entry_valid),
        .o_map_count    (o_map_count),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic longint sq_span(input int ax, input int ay, input int bx, input int by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return dx * dx + dy * dy;
    endfunction

    function automatic string describe(input t_result r);
        return $sformatf("kind=%0d act=%0d slot=%0d x=%0d y=%0d col=%0d vld=%0d cnt=%0d last=%0d",
                         r.kind, r.action, r.slot, r.entry_x, r.entry_y, r.entry_color,
                         r.entry_valid, r.map_count, r.last);
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // append one report to the tail of the prediction queue
    task automatic queue_report(input t_result rep);
        predicted_reports = {predicted_reports, rep};
    endtask

    // Applies one request to the predicted map and queues the reports it should produce.
    task automatic update_landmark_map(input t_op op, input logic signed [POS_W-1:0] px,
                                       input logic signed [POS_W-1:0] py,
                                       input logic [COLOR_W-1:0] pc);
        t_result r;
        t_action act;
        longint  d;
        longint  best;
        int      best_i;
        int      slot_i;
        bit      hit;
        bit      settled;
        bit      replaced;
        r        = '0;
        r.last   = 1'b1;
        slot_i   = 0;
        settled  = 1'b0;
        replaced = 1'b0;
        if (op == OP_DUMP) begin
            first_frame_open = 1'b0;
            r.kind = KIND_ENTRY;
            if (landmark_cnt == 0) begin
                queue_report(r);
            end else begin
                for (int i = 0; i < landmark_cnt; i++) begin
                    r.slot        = SLOT_W'(i);
                    r.entry_x     = landmarks[i].x;
                    r.entry_y     = landmarks[i].y;
                    r.entry_color = landmarks[i].color;
                    r.entry_valid = 1'b1;
                    r.map_count   = COUNT_W'(landmark_cnt);
                    r.last        = (i == landmark_cnt - 1);
                    queue_report(r);
                end
            end
        end else begin
            if (sq_span($signed(px), $signed(py), 0, 0) > longint'(range_lim) * range_lim) begin
                act = ACT_OUT_OF_RANGE;
                settled = 1'b1;
            end else if (!first_frame_open) begin
                hit    = 1'b0;
                best   = 0;
                best_i = 0;
                for (int i = 0; i < landmark_cnt; i++) begin
                    d = sq_span($signed(px), $signed(py),
                                $signed(landmarks[i].x), $signed(landmarks[i].y));
                    if (!hit || d < best) begin
                        hit    = 1'b1;
                        best   = d;
                        best_i = i;
                    end
                end
                if (hit && best <= longint'(match_dist) * match_dist) begin
                    if (landmarks[best_i].color == pc || pc == COLOR_UNKNOWN) begin
                        act     = ACT_IGNORED;
                        slot_i  = best_i;
                        settled = 1'b1;
                    end else begin
                        // conflicting color: drop the old entry, close the gap
                        for (int i = best_i; i + 1 < landmark_cnt; i++)
                            landmarks[i] = landmarks[i + 1];
                        landmark_cnt--;
                        replaced = 1'b1;
                    end
                end
            end
            if (!settled) begin
                if (landmark_cnt < MAP_DEPTH) begin
                    landmarks[landmark_cnt] = '{x: px, y: py, color: pc};
                    slot_i = landmark_cnt;
                    landmark_cnt++;
                    act = replaced ? ACT_REPLACED : ACT_ADDED;
                end else begin
                    act = ACT_MAP_FULL;
                end
            end
            r.kind      = KIND_STATUS;
            r.action    = act;
            r.slot      = SLOT_W'(slot_i);
            r.map_count = COUNT_W'(landmark_cnt);
            queue_report(r);
        end
    endtask

    task automatic send_request(input t_stim_row row, input bit with_gaps);
        t_result typed_report;
        if (with_gaps && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk) start <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_op         <= row.op;
        i_pos_x      <= row.x;
        i_pos_y      <= row.y;
        i_cone_color <= row.color;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        update_landmark_map(row.op, row.x, row.y, row.color);
        if (row.typed) begin
            typed_report           = '0;
            typed_report.kind      = KIND_STATUS;
            typed_report.action    = row.action;
            typed_report.slot      = row.slot;
            typed_report.map_count = row.count;
            typed_report.last      = 1'b1;
            predicted_reports[$]   = typed_report;
        end
    endtask

    task automatic drain_reports();
        @(negedge i_clk) start <= 1'b0;
        while (predicted_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write, then read back
    task automatic write_reg(input t_reg idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        if (idx == REG_MATCH_DIST)
            match_dist = val;
        else
            range_lim = val;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        if (prdata !== PDATA_W'(val))
            note_mismatch($sformatf("reg %0d read back %0h, wrote %0h", idx, prdata, val));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            got.kind        = t_kind'(o_kind);
            got.action      = t_action'(o_action);
            got.slot        = o_slot;
            got.entry_x     = o_entry_x;
            got.entry_y     = o_entry_y;
            got.entry_color = o_entry_color;
            got.entry_valid = o_entry_valid;
            got.map_count   = o_map_count;
            got.last        = o_last;
            if (predicted_reports.size() == 0) begin
                note_mismatch({"unexpected result ", describe(got)});
            end else begin
                want = predicted_reports.pop_front();
                if (got.kind !== want.kind || got.action !== want.action
                        || got.slot !== want.slot || got.entry_x !== want.entry_x
                        || got.entry_y !== want.entry_y || got.entry_color !== want.entry_color
                        || got.entry_valid !== want.entry_valid
                        || got.map_count !== want.map_count || got.last !== want.last)
                    note_mismatch({"expected ", describe(want), " got ", describe(got)});
            end
        end
    end

    // no progress for too long: give up
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid === 1'b1 || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("cone_map_nearest_match_unit verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_stim_row row;
        int        roll;
        int        idx;
        int        span;
        int        half;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i], 1'b1);

        for (int p = 0; p < N_PHASES; p++) begin
            drain_reports();
            write_reg(REG_MATCH_DIST, PHASE_MATCH[p]);
            write_reg(REG_RANGE_LIMIT, PHASE_RANGE[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                row       = '0;
                roll      = $urandom_range(0, 99);
                row.op    = (roll < 9) ? OP_DUMP : OP_DETECT;
                row.x     = POS_W'($urandom);
                row.y     = POS_W'($urandom);
                row.color = COLOR_W'($urandom);
                if (row.op == OP_DETECT && roll < 55 && landmark_cnt > 0) begin
                    // land near a known cone, around the match radius
                    idx   = $urandom_range(0, landmark_cnt - 1);
                    span  = (match_dist > 2000) ? 2000 : match_dist + 8;
                    row.x = landmarks[idx].x + POS_W'($urandom_range(0, 2 * span)) - POS_W'(span);
                    row.y = landmarks[idx].y + POS_W'($urandom_range(0, 2 * span)) - POS_W'(span);
                    case ($urandom_range(0, 2))
                        0: row.color = landmarks[idx].color;
                        1: row.color = COLOR_UNKNOWN;
                        default: row.color = COLOR_W'($urandom);
                    endcase
                end else if (row.op == OP_DETECT && roll < 90) begin
                    half  = range_lim * 7 / 10;
                    row.x = POS_W'(int'($urandom_range(0, 2 * half)) - half);
                    row.y = POS_W'(int'($urandom_range(0, 2 * half)) - half);
                    if ($urandom_range(0, 3) != 0)
                        row.color = COLOR_W'($urandom_range(0, 4));
                end
                send_request(row, p != N_PHASES - 1);
            end
        end

        drain_reports();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && predicted_reports.size() == 0)
            $display("cone_map_nearest_match_unit verification clean");
        else
            $display("cone_map_nearest_match_unit verification failed");
        $finish;
    end

endmodule
